### rtl/cpt_pkg.sv
// ============================================================================
// cpt_pkg
// Shared types and constants for the path tokenizer: character codes,
// record kinds, error codes and the record layout carried to the output.
// ============================================================================
package cpt_pkg;

    localparam int NAME_LIMIT_DEF   = 32;
    localparam int MAX_SEGMENTS_DEF = 8;

    localparam int CH_W    = 8;
    localparam int TDATA_W = 40;

    localparam logic [CH_W-1:0] CH_END   = 8'd0;
    localparam logic [CH_W-1:0] CH_SLASH = 8'd47;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CH_W-1:0] CH_NINE  = 8'd57;

    localparam logic [15:0] VALUE_MAX = 16'hFFFF;

    localparam logic KIND_SEG = 1'b0;
    localparam logic KIND_END = 1'b1;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_EMPTY_SEG = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG  = 2'd2;
    localparam logic [1:0] ERR_TOO_MANY  = 2'd3;

    // Output record FIFO depth; must be a power of two and at least two.
    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic        kind;
        logic [2:0]  seg_number;
        logic [5:0]  seg_length;
        logic        is_numeric;
        logic [15:0] index_value;
        logic        path_ok;
        logic [1:0]  error_code;
        logic [3:0]  seg_count;
        logic        last;
    } rec_t;

    // Records produced by one input byte: count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        rec_t       rec0;
        rec_t       rec1;
    } rec_pair_t;

endpackage

### rtl/cpt_parser.sv
// ============================================================================
// cpt_parser
// Per-byte path parser. Holds the segment state and, for each accepted
// byte, produces the next state and up to two result records.
// ============================================================================
module cpt_parser
    import cpt_pkg::*;
#(
    parameter int NAME_LIMIT   = NAME_LIMIT_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_accept,
    input  logic [CH_W-1:0] in_ch,
    output rec_pair_t       out_recs
);

    localparam int LEN_W = $clog2(NAME_LIMIT + 1);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_PATH  = 2'd1;
    localparam logic [1:0] MODE_ERROR = 2'd2;
    localparam logic [1:0] MODE_EMPTY = 2'd3;

    logic [1:0]       mode_reg,  mode_next;
    logic [LEN_W-1:0] len_reg,   len_next;
    logic             num_reg,   num_next;
    logic [15:0]      val_reg,   val_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [1:0]       fault_reg, fault_next;

    logic [LEN_W+5:0] len_ext;
    logic [CNT_W+3:0] cnt_ext;
    logic [CNT_W+3:0] cnt_inc_ext;
    logic [CNT_W-1:0] cnt_inc;
    logic [CH_W-1:0]  digit;
    logic [19:0]      val_mul;
    logic             is_digit;
    logic             room;
    rec_t             seg_rec;
    rec_t             end_rec;

    assign len_ext     = {6'b0, len_reg};
    assign cnt_ext     = {4'b0, cnt_reg};
    assign cnt_inc     = cnt_reg + 1'b1;
    assign cnt_inc_ext = {4'b0, cnt_inc};
    assign digit       = in_ch - CH_ZERO;
    assign is_digit    = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
    assign val_mul     = ({4'b0, val_reg} << 3) + ({4'b0, val_reg} << 1)
                         + {12'b0, digit};
    assign room        = cnt_reg < CNT_W'(MAX_SEGMENTS);

    always_comb begin
        seg_rec             = '0;
        seg_rec.kind        = KIND_SEG;
        seg_rec.seg_number  = cnt_ext[2:0];
        seg_rec.seg_length  = len_ext[5:0];
        seg_rec.is_numeric  = num_reg;
        seg_rec.index_value = num_reg ? val_reg : 16'd0;

        end_rec      = '0;
        end_rec.kind = KIND_END;
        end_rec.last = 1'b1;
    end

    always_comb begin
        mode_next  = mode_reg;
        len_next   = len_reg;
        num_next   = num_reg;
        val_next   = val_reg;
        cnt_next   = cnt_reg;
        fault_next = fault_reg;
        out_recs   = '0;

        if (in_ch == CH_END) begin
            if (mode_reg == MODE_PATH && len_reg != '0) begin
                if (room) begin
                    out_recs.count             = 2'd2;
                    out_recs.rec0              = seg_rec;
                    out_recs.rec1              = end_rec;
                    out_recs.rec1.path_ok      = 1'b1;
                    out_recs.rec1.seg_count    = cnt_inc_ext[3:0];
                end else begin
                    out_recs.count             = 2'd1;
                    out_recs.rec0              = end_rec;
                    out_recs.rec0.error_code   = ERR_TOO_MANY;
                end
            end else begin
                out_recs.count = 2'd1;
                out_recs.rec0  = end_rec;
                if (mode_reg == MODE_ERROR) begin
                    out_recs.rec0.error_code = fault_reg;
                end else begin
                    out_recs.rec0.path_ok   = 1'b1;
                    out_recs.rec0.seg_count = cnt_ext[3:0];
                end
            end
            // The terminator re-arms the parser for the next path.
            mode_next  = MODE_START;
            len_next   = '0;
            num_next   = 1'b1;
            val_next   = '0;
            cnt_next   = '0;
            fault_next = ERR_NONE;
        end else if (mode_reg == MODE_ERROR) begin
            // Bytes after an error are dropped until the terminator.
        end else if (mode_reg == MODE_EMPTY) begin
            mode_next  = MODE_ERROR;
            fault_next = ERR_EMPTY_SEG;
            len_next   = '0;
            num_next   = 1'b1;
            val_next   = '0;
        end else if (in_ch == CH_SLASH) begin
            if (mode_reg == MODE_START) begin
                mode_next = MODE_PATH;
            end else if (len_reg == '0) begin
                mode_next = MODE_EMPTY;
            end else begin
                if (room) begin
                    out_recs.count     = 2'd1;
                    out_recs.rec0      = seg_rec;
                    out_recs.rec0.last = 1'b1;
                    cnt_next           = cnt_inc;
                end else begin
                    mode_next  = MODE_ERROR;
                    fault_next = ERR_TOO_MANY;
                end
                len_next = '0;
                num_next = 1'b1;
                val_next = '0;
            end
        end else begin
            mode_next = MODE_PATH;
            if (len_reg >= LEN_W'(NAME_LIMIT)) begin
                mode_next  = MODE_ERROR;
                fault_next = ERR_TOO_LONG;
                len_next   = '0;
                num_next   = 1'b1;
                val_next   = '0;
            end else begin
                len_next = len_reg + 1'b1;
                if (num_reg) begin
                    if (!is_digit) begin
                        num_next = 1'b0;
                        val_next = '0;
                    end else if (val_mul > {4'b0, VALUE_MAX}) begin
                        val_next = VALUE_MAX;
                    end else begin
                        val_next = val_mul[15:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_START;
            len_reg   <= '0;
            num_reg   <= 1'b1;
            val_reg   <= '0;
            cnt_reg   <= '0;
            fault_reg <= ERR_NONE;
        end else if (in_accept) begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            num_reg   <= num_next;
            val_reg   <= val_next;
            cnt_reg   <= cnt_next;
            fault_reg <= fault_next;
        end
    end

endmodule

### rtl/cpt_rec_fifo.sv
// ============================================================================
// cpt_rec_fifo
// Small record queue between the parser and the output channel. Takes up
// to two records per cycle while space_ok is high and hands out one per transaction.
// ============================================================================
module cpt_rec_fifo
    import cpt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  rec_pair_t push_recs,
    output logic      space_ok,
    output logic      out_valid,
    input  logic      out_ready,
    output rec_t      out_rec
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int FILL_W = PTR_W + 1;

    rec_t              mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0]  wr_ptr_inc;
    logic              pop;
    logic              wr0;
    logic              wr1;

    assign pop        = out_valid && out_ready;
    assign wr0        = push && (push_recs.count != 2'd0);
    assign wr1        = push && (push_recs.count == 2'd2);
    assign wr_ptr_inc = wr_ptr_reg + 1'b1;
    assign out_valid  = fill_reg != '0;
    assign out_rec    = mem_reg[rd_ptr_reg];
    // Room for the two records a single byte can cause.
    assign space_ok   = fill_reg <= FILL_W'(FIFO_DEPTH - 2);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        if (wr1) begin
            wr_ptr_next = wr_ptr_reg + 2'd2;
        end else if (wr0) begin
            wr_ptr_next = wr_ptr_inc;
        end
        fill_next = fill_reg + FILL_W'(wr0) + FILL_W'(wr1) - FILL_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (wr0) begin
            mem_reg[wr_ptr_reg] <= push_recs.rec0;
        end
        if (wr1) begin
            mem_reg[wr_ptr_inc] <= push_recs.rec1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

### rtl/config_path_tokenizer.sv
// Each accepted byte yields zero to two records, written to the record queue.
// Throughput: one path byte per cycle while the queue has room for two records.
// The terminating byte of a path may yield two records, which leave one per transaction;
// the four-entry record queue takes input while at least two entries are free.
// Reset (aresetn low at a clock edge) empties the queue and re-arms the parser
// at the start of a path.
// ============================================================================
// config_path_tokenizer
// Streaming tokenizer for slash-separated paths: reports each segment with
// its length, digit check and decimal value, then an end record.
// ============================================================================
module config_path_tokenizer
    import cpt_pkg::*;
#(
    parameter int NAME_LIMIT   = NAME_LIMIT_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [CH_W-1:0]    s_axis_tdata,   // [7:0] ch

    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [2:0] seg_number, [8:3] seg_length, [9] is_numeric, [25:10] index_value,
    // [26] path_ok, [28:27] error_code, [32:29] seg_count, [39:33] zero
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic [0:0]         m_axis_tuser,   // [0] kind
    output logic               m_axis_tlast
);

    logic      in_accept;
    logic      space_ok;
    rec_pair_t recs;
    rec_t      out_rec;

    assign s_axis_tready = space_ok;
    assign in_accept     = s_axis_tvalid && space_ok;

    cpt_parser #(
        .NAME_LIMIT   (NAME_LIMIT),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_ch     (s_axis_tdata),
        .out_recs  (recs)
    );

    cpt_rec_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_accept),
        .push_recs (recs),
        .space_ok  (space_ok),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_rec   (out_rec)
    );

    assign m_axis_tdata = {7'b0, out_rec.seg_count, out_rec.error_code, out_rec.path_ok,
                           out_rec.index_value, out_rec.is_numeric, out_rec.seg_length,
                           out_rec.seg_number};
    assign m_axis_tuser = out_rec.kind;
    assign m_axis_tlast = out_rec.last;

endmodule

### tb/sv/tb_config_path_tokenizer.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_config_path_tokenizer
// Self-checking bench for the path tokenizer. Paths are streamed one byte per
// transaction, and a behavioral model in the bench predicts every segment and
// end record. Stimulus covers basic paths, the length and segment-count
// limits, a long output stall, and random well-formed and broken paths under
// several idle and stall mixes.
// ============================================================================
module tb_config_path_tokenizer;
    import cpt_pkg::*;

    typedef enum logic [1:0] {
        AT_START    = 2'd0,
        IN_PATH     = 2'd1,
        IN_ERROR    = 2'd2,
        AFTER_EMPTY = 2'd3
    } parse_mode_t;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [CH_W-1:0]    s_axis_tdata  = '0;   // [7:0] ch
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // [2:0] seg_number, [8:3] seg_length, [9] is_numeric, [25:10] index_value,
    // [26] path_ok, [28:27] error_code, [32:29] seg_count, [39:33] zero
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [0:0]         m_axis_tuser;         // [0] kind
    logic               m_axis_tlast;

    // Model state of the tokenizer.
    parse_mode_t        pmode      = AT_START;
    int unsigned        seg_len    = 0;
    logic               seg_digits = 1'b1;
    int unsigned        seg_value  = 0;
    int unsigned        segs_done  = 0;
    logic [1:0]         seg_fault  = ERR_NONE;

    rec_t               expected_recs[$];
    rec_t               head_rec;
    logic [CH_W-1:0]    path_buf[$];

    int                 error_count    = 0;
    int                 bytes_sent     = 0;
    int                 paths_sent     = 0;
    int                 seg_recs_made  = 0;
    int                 paths_ok       = 0;
    int                 paths_bad[4]   = '{0, 0, 0, 0};

    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 hold_len       = 0;
    int                 hold_seq       = 0;
    int                 hold_seen      = 0;
    int                 hold_left      = 0;

    config_path_tokenizer #(
        .NAME_LIMIT   (NAME_LIMIT_DEF),
        .MAX_SEGMENTS (MAX_SEGMENTS_DEF)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Queue helpers
    // ------------------------------------------------------------------------
    function automatic void add_expected(rec_t r);
        expected_recs.insert(expected_recs.size(), r);
    endfunction

    function automatic void add_path_byte(logic [CH_W-1:0] b);
        path_buf.insert(path_buf.size(), b);
    endfunction

    // ------------------------------------------------------------------------
    // Path model
    // ------------------------------------------------------------------------
    function automatic void clear_segment();
        seg_len    = 0;
        seg_digits = 1'b1;
        seg_value  = 0;
    endfunction

    function automatic void flag_error(logic [1:0] code);
        seg_fault = code;
        pmode     = IN_ERROR;
        clear_segment();
    endfunction

    function automatic void close_segment(logic is_last);
        rec_t r;
        if (segs_done >= MAX_SEGMENTS_DEF) begin
            flag_error(ERR_TOO_MANY);
        end else begin
            r            = '0;
            r.kind       = KIND_SEG;
            r.seg_number = segs_done[2:0];
            r.seg_length = seg_len[5:0];
            r.is_numeric = seg_digits;
            r.index_value = seg_digits ? seg_value[15:0] : 16'd0;
            r.last       = is_last;
            add_expected(r);
            seg_recs_made++;
            segs_done++;
            clear_segment();
        end
    endfunction

    function automatic void predict_path_byte(logic [CH_W-1:0] ch);
        rec_t r;
        if (ch == CH_END) begin
            if (pmode == IN_PATH && seg_len != 0) begin
                close_segment(1'b0);
            end
            r      = '0;
            r.kind = KIND_END;
            r.last = 1'b1;
            if (pmode == IN_ERROR) begin
                r.error_code = seg_fault;
                paths_bad[seg_fault]++;
            end else begin
                r.path_ok   = 1'b1;
                r.seg_count = segs_done[3:0];
                paths_ok++;
            end
            add_expected(r);
            pmode     = AT_START;
            segs_done = 0;
            seg_fault = ERR_NONE;
            clear_segment();
        end else if (pmode == IN_ERROR) begin
            // Everything up to the terminator is dropped.
        end else if (pmode == AFTER_EMPTY) begin
            flag_error(ERR_EMPTY_SEG);
        end else if (ch == CH_SLASH) begin
            if (pmode == AT_START) begin
                pmode = IN_PATH;
            end else if (seg_len == 0) begin
                pmode = AFTER_EMPTY;
            end else begin
                close_segment(1'b1);
            end
        end else begin
            pmode = IN_PATH;
            if (seg_len >= NAME_LIMIT_DEF) begin
                flag_error(ERR_TOO_LONG);
            end else begin
                seg_len++;
                if (seg_digits) begin
                    if (ch < CH_ZERO || ch > CH_NINE) begin
                        seg_digits = 1'b0;
                        seg_value  = 0;
                    end else begin
                        seg_value = seg_value * 10 + (int'(ch) - int'(CH_ZERO));
                        if (seg_value > VALUE_MAX) begin
                            seg_value = VALUE_MAX;
                        end
                    end
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    task automatic send_path_byte(logic [CH_W-1:0] ch);
        int gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct && gap < 40) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= CH_W'($urandom);
            gap++;
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        do @(posedge aclk); while (!s_axis_tready);
        predict_path_byte(ch);
        bytes_sent++;
    endtask

    // Sends path_buf followed by the terminating byte.
    task automatic send_path();
        foreach (path_buf[i]) begin
            send_path_byte(path_buf[i]);
        end
        send_path_byte(CH_END);
        paths_sent++;
    endtask

    task automatic send_text(string s);
        path_buf.delete();
        for (int i = 0; i < s.len(); i++) begin
            add_path_byte(s[i]);
        end
        send_path();
    endtask

    function automatic logic [CH_W-1:0] random_name_byte();
        logic [CH_W-1:0] b;
        do b = CH_W'($urandom_range(255, 1)); while (b == CH_SLASH);
        return b;
    endfunction

    // Mostly well-formed paths with random content; some noise paths.
    task automatic make_random_path();
        int nseg;
        int len;
        int r;
        logic numeric;
        path_buf.delete();
        if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(12)) begin
                add_path_byte(($urandom_range(3) == 0) ? CH_SLASH : random_name_byte());
            end
        end else begin
            if ($urandom_range(1) == 1) begin
                add_path_byte(CH_SLASH);
            end
            nseg = ($urandom_range(9) == 0) ? $urandom_range(10, 9) : $urandom_range(8);
            for (int i = 0; i < nseg; i++) begin
                if (i > 0) begin
                    add_path_byte(CH_SLASH);
                end
                numeric = 1'($urandom_range(1));
                r = $urandom_range(99);
                if (r < 4) begin
                    len = 0;
                end else if (r < 8) begin
                    len = NAME_LIMIT_DEF + $urandom_range(1);
                end else begin
                    len = numeric ? $urandom_range(1, 7) : $urandom_range(1, 5);
                end
                repeat (len) begin
                    add_path_byte(numeric ? CH_W'(CH_ZERO + $urandom_range(9))
                                          : random_name_byte());
                end
            end
            if ($urandom_range(3) == 0) begin
                add_path_byte(CH_SLASH);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_recs.size() == 0) begin
                $error("unexpected output transaction: tdata %h tuser %b tlast %b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                error_count++;
            end else begin
                head_rec = expected_recs.pop_front();
                check_field("kind",        head_rec.kind,        m_axis_tuser[0]);
                check_field("seg_number",  head_rec.seg_number,  m_axis_tdata[2:0]);
                check_field("seg_length",  head_rec.seg_length,  m_axis_tdata[8:3]);
                check_field("is_numeric",  head_rec.is_numeric,  m_axis_tdata[9]);
                check_field("index_value", head_rec.index_value, m_axis_tdata[25:10]);
                check_field("path_ok",     head_rec.path_ok,     m_axis_tdata[26]);
                check_field("error_code",  head_rec.error_code,  m_axis_tdata[28:27]);
                check_field("seg_count",   head_rec.seg_count,   m_axis_tdata[32:29]);
                check_field("tdata_pad",   0,                    m_axis_tdata[39:33]);
                check_field("last",        head_rec.last,        m_axis_tlast);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        send_text("");
        send_text("/");
        send_text("/12/x/");
        send_text("a//b");
        send_text("99999");
        path_buf.delete();
        add_path_byte(8'hFF);
        add_path_byte(8'h01);
        send_path();
    endtask

    task automatic test_limits();
        // The 33rd character overruns the name limit.
        path_buf.delete();
        repeat (NAME_LIMIT_DEF + 1) add_path_byte("z");
        send_path();
        // Nine segments, the last one closed by the terminator.
        send_text("1/2/3/4/5/6/7/8/9");
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len       = 300;
        hold_seq++;
        send_text("/1/2/3/4/5/6/7/8/");
        send_text("a/b/c/d/e");
    endtask

    task automatic test_random_paths(int idle_pct, int stall_pct, int n_bytes);
        int stop_at;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at        = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            make_random_path();
            send_path();
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_limits();
        test_backpressure();
        test_random_paths(0, 0, 380);
        test_random_paths(81, 0, 380);
        test_random_paths(0, 81, 380);
        test_random_paths(14, 14, 380);

        @(negedge aclk);
        s_axis_tvalid  <= 1'b0;
        recv_stall_pct = 0;
        while (expected_recs.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Streamed %0d bytes in %0d paths; %0d segment records predicted.",
                 bytes_sent, paths_sent, seg_recs_made);
        $display("Path ends: %0d valid, %0d empty-segment, %0d too-long, %0d too-many.",
                 paths_ok, paths_bad[ERR_EMPTY_SEG], paths_bad[ERR_TOO_LONG],
                 paths_bad[ERR_TOO_MANY]);
        if (error_count == 0 && expected_recs.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
rtl/cpt_pkg.sv
rtl/cpt_parser.sv
rtl/cpt_rec_fifo.sv
rtl/config_path_tokenizer.sv
tb/sv/tb_config_path_tokenizer.sv
